/* rtl/core/rtac_pkg.sv */
// shared types and constants for the region table access checker
package rtac_pkg;

    localparam int MAX_REGIONS = 16;
    localparam int PAGE_BITS   = 12;
    localparam int ADDR_BITS   = 39;
    localparam int LEN_BITS    = 32;
    localparam int FLAG_W      = 4;
    localparam int STAT_W      = 3;
    localparam int OP_W        = 2;
    localparam int CFG_IDX_W   = 1;

    localparam int IDX_W = $clog2(MAX_REGIONS);
    localparam int CNT_W = $clog2(MAX_REGIONS + 1);
    localparam int SUM_W = ADDR_BITS + 1;

    // flag bit positions
    localparam int FLAG_READ  = 0;
    localparam int FLAG_WRITE = 1;
    localparam int FLAG_STACK = 3;

    typedef logic [ADDR_BITS-1:0] addr_t;
    typedef logic [SUM_W-1:0]     sum_t;

    localparam addr_t WIN_LOW_RST  = ADDR_BITS'(64'd2097152);
    localparam addr_t WIN_HIGH_RST = '1;
    localparam sum_t  PAGE_LOW     = SUM_W'((65'd1 << PAGE_BITS) - 65'd1);

    typedef enum logic [OP_W-1:0] {
        OP_MAP   = 2'd0,
        OP_FIND  = 2'd1,
        OP_CHECK = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_INVALID   = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_DENIED    = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIN_LOW  = 1'b0,
        CFG_WIN_HIGH = 1'b1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CALC,
        S_ROUND,
        S_RANGE,
        S_LH_EVAL,
        S_SCAN,
        S_SHIFT,
        S_INSERT,
        S_RESULT
    } state_t;

    typedef struct packed {
        addr_t             base;
        addr_t             limit;
        logic [FLAG_W-1:0] flags;
    } region_t;

endpackage

/* rtl/core/rtac_ram.sv */
// generic single write port ram with registered read
module rtac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/region_table_access_checker.sv */
// top level of the region table access checker: sequencer, table walk and result register
//
// Keeps up to 16 disjoint address regions sorted by base address in a small ram, each with
// read, write, exec and stack flags. A word on the s_ channel carries one of four operations:
// map rounds the range out to 4 KiB pages, checks it against the user window and for overlap
// and inserts it in order; find returns the region holding an address; check walks the regions
// covering a range testing read or write permission, denying writes that touch the guard page
// at the bottom of a stack region; clear empties the table. Every word yields exactly one
// result word on the m_ channel. The block takes one word at a time: s_ready is high only
// while the sequencer is idle, and a finished result waits in its own output register, so the
// next word can be taken before the previous result is collected. The walk streams through
// the single ram read port, one entry per cycle; find first tests the remembered last region
// and scans the table only on a miss, and map scans the table, then opens a slot from the top
// down and inserts; clear goes straight to the result without a walk.
// The window registers are written through cfg_wr_en/cfg_index/cfg_wdata while idle: the
// user must keep to this, since the block itself does not enforce it.
module region_table_access_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration writes
    input  logic                           cfg_wr_en,
    input  logic [rtac_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rtac_pkg::ADDR_BITS-1:0] cfg_wdata,
    // request words
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [rtac_pkg::OP_W-1:0]      s_operation,
    input  logic [rtac_pkg::ADDR_BITS-1:0] s_address,
    input  logic [rtac_pkg::LEN_BITS-1:0]  s_length,
    input  logic [rtac_pkg::FLAG_W-1:0]    s_new_flags,
    input  logic                           s_write_access,
    // result words
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [rtac_pkg::STAT_W-1:0]    m_status,
    output logic [rtac_pkg::IDX_W-1:0]     m_region_index,
    output logic [rtac_pkg::ADDR_BITS-1:0] m_found_start,
    output logic [rtac_pkg::ADDR_BITS-1:0] m_found_end,
    output logic [rtac_pkg::FLAG_W-1:0]    m_found_flags
);
    import rtac_pkg::*;

    // control state
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  lh_reg, lh_next;
    logic              lh_valid_reg, lh_valid_next;
    logic              pend_valid_reg, pend_valid_next;
    logic              m_valid_reg, m_valid_next;
    addr_t             win_low_reg, win_low_next;
    addr_t             win_high_reg, win_high_next;

    // working registers for the word in flight
    op_t               op_reg, op_next;
    addr_t             start_reg, start_next;
    addr_t             cur_reg, cur_next;
    logic [LEN_BITS-1:0] len_reg, len_next;
    logic [FLAG_W-1:0] flags_reg, flags_next;
    logic              wr_reg, wr_next;
    sum_t              end_reg, end_next;
    logic [CNT_W-1:0]  issue_reg, issue_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [IDX_W-1:0]  pend_idx_reg, pend_idx_next;

    // staged result and output register
    status_t           res_status_reg, res_status_next;
    logic [IDX_W-1:0]  res_idx_reg, res_idx_next;
    region_t           res_region_reg, res_region_next;
    status_t           out_status_reg, out_status_next;
    logic [IDX_W-1:0]  out_idx_reg, out_idx_next;
    region_t           out_region_reg, out_region_next;

    // table ram
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    region_t           ram_wdata, ram_rdata;

    // shared compare unit and walk control
    logic              accept;
    logic              out_free;
    logic              hit, overlap, below, need_ok, guard, denied, walk_done;
    logic              scan_issue, shift_issue, sweep_end, shift_end, lh_usable;
    logic              range_ok;
    addr_t             lo_sel, offset;
    logic [CNT_W-1:0]  issue_m1;
    logic [CNT_W-1:0]  pend_idx_ext;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // entry under test against the current walk address
    assign hit      = (ram_rdata.base <= cur_reg) && (cur_reg < ram_rdata.limit);
    assign overlap  = ({1'b0, ram_rdata.base} < end_reg) && (start_reg < ram_rdata.limit);
    assign below    = (ram_rdata.base <= start_reg);
    assign need_ok  = wr_reg ? ram_rdata.flags[FLAG_WRITE] : ram_rdata.flags[FLAG_READ];
    assign offset   = cur_reg - ram_rdata.base;
    // writes into the lowest page of a stack region hit the guard page
    assign guard    = wr_reg && ram_rdata.flags[FLAG_STACK] &&
                      (offset[ADDR_BITS-1:PAGE_BITS] == '0);
    assign denied   = !need_ok || guard;
    assign walk_done = ({1'b0, ram_rdata.limit} >= end_reg);

    assign issue_m1     = issue_reg - 1'b1;
    assign pend_idx_ext = CNT_W'(pend_idx_reg);
    assign scan_issue   = (issue_reg < count_reg);
    assign shift_issue  = (issue_reg > pos_reg);
    assign sweep_end    = !pend_valid_reg && !scan_issue;
    assign shift_end    = !pend_valid_reg && !shift_issue;
    assign lh_usable    = lh_valid_reg && (CNT_W'(lh_reg) < count_reg);

    // window test, map uses the page-aligned base
    assign lo_sel   = (op_reg == OP_MAP) ? start_reg : cur_reg;
    assign range_ok = (win_low_reg <= lo_sel) && ({1'b0, lo_sel} < end_reg) &&
                      (end_reg <= {1'b0, win_high_reg});

    // ram addressing: idle reads the last hit so find can test it straight away
    always_comb begin
        unique case (state_reg)
            S_SCAN:  ram_raddr = issue_reg[IDX_W-1:0];
            S_SHIFT: ram_raddr = issue_m1[IDX_W-1:0];
            default: ram_raddr = lh_reg;
        endcase
        ram_we    = (state_reg == S_INSERT) || ((state_reg == S_SHIFT) && pend_valid_reg);
        ram_waddr = (state_reg == S_INSERT) ? pos_reg[IDX_W-1:0]
                                            : IDX_W'(pend_idx_ext + 1'b1);
        ram_wdata = ram_rdata;
        if (state_reg == S_INSERT) begin
            ram_wdata.base  = start_reg;
            ram_wdata.limit = end_reg[ADDR_BITS-1:0];
            ram_wdata.flags = flags_reg;
        end
    end

    rtac_ram #(
        .WIDTH ($bits(region_t)),
        .DEPTH (MAX_REGIONS)
    ) u_table (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (op_t'(s_operation))
                        OP_MAP, OP_CHECK: state_next = S_CALC;
                        OP_FIND:          state_next = lh_usable ? S_LH_EVAL : S_SCAN;
                        default:          state_next = S_RESULT;
                    endcase
                end
            end
            S_CALC:    state_next = (op_reg == OP_MAP) ? S_ROUND : S_RANGE;
            S_ROUND:   state_next = S_RANGE;
            S_RANGE:   state_next = range_ok ? S_SCAN : S_RESULT;
            S_LH_EVAL: state_next = hit ? S_RESULT : S_SCAN;
            S_SCAN: begin
                if (pend_valid_reg) begin
                    case (op_reg)
                        OP_MAP: begin
                            if (overlap) begin
                                state_next = S_RESULT;
                            end
                        end
                        OP_FIND: begin
                            if (hit) begin
                                state_next = S_RESULT;
                            end
                        end
                        OP_CHECK: begin
                            if (hit && (denied || walk_done)) begin
                                state_next = S_RESULT;
                            end
                        end
                        default: state_next = S_RESULT;
                    endcase
                end else if (sweep_end) begin
                    if ((op_reg == OP_MAP) && (count_reg < CNT_W'(MAX_REGIONS))) begin
                        state_next = S_SHIFT;
                    end else begin
                        state_next = S_RESULT;
                    end
                end
            end
            S_SHIFT: begin
                if (shift_end) begin
                    state_next = S_INSERT;
                end
            end
            S_INSERT: state_next = S_RESULT;
            S_RESULT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        count_next      = count_reg;
        lh_next         = lh_reg;
        lh_valid_next   = lh_valid_reg;
        pend_valid_next = 1'b0;
        pend_idx_next   = pend_idx_reg;
        win_low_next    = win_low_reg;
        win_high_next   = win_high_reg;
        op_next         = op_reg;
        start_next      = start_reg;
        cur_next        = cur_reg;
        len_next        = len_reg;
        flags_next      = flags_reg;
        wr_next         = wr_reg;
        end_next        = end_reg;
        issue_next      = issue_reg;
        pos_next        = pos_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        res_region_next = res_region_reg;
        out_status_next = out_status_reg;
        out_idx_next    = out_idx_reg;
        out_region_next = out_region_reg;
        m_valid_next    = m_valid_reg && !m_ready;

        if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_WIN_LOW:  win_low_next  = cfg_wdata;
                CFG_WIN_HIGH: win_high_next = cfg_wdata;
                default:      win_low_next  = win_low_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next         = op_t'(s_operation);
                    start_next      = {s_address[ADDR_BITS-1:PAGE_BITS], {PAGE_BITS{1'b0}}};
                    cur_next        = s_address;
                    len_next        = s_length;
                    flags_next      = s_new_flags;
                    wr_next         = s_write_access;
                    issue_next      = '0;
                    pos_next        = '0;
                    res_status_next = STAT_OK;
                    res_idx_next    = '0;
                    res_region_next = '0;
                    if (op_t'(s_operation) == OP_CLEAR) begin
                        count_next    = '0;
                        lh_next       = '0;
                        lh_valid_next = 1'b0;
                    end
                end
            end
            S_CALC: begin
                end_next = SUM_W'(cur_reg) + SUM_W'(len_reg);
            end
            S_ROUND: begin
                // round the end up to a page
                end_next = (end_reg + PAGE_LOW) & ~PAGE_LOW;
            end
            S_RANGE: begin
                if (!range_ok) begin
                    res_status_next = STAT_INVALID;
                end
            end
            S_LH_EVAL: begin
                if (hit) begin
                    res_idx_next    = lh_reg;
                    res_region_next = ram_rdata;
                end
            end
            S_SCAN: begin
                pend_valid_next = scan_issue;
                pend_idx_next   = issue_reg[IDX_W-1:0];
                if (scan_issue) begin
                    issue_next = issue_reg + 1'b1;
                end
                if (pend_valid_reg) begin
                    case (op_reg)
                        OP_MAP: begin
                            if (overlap) begin
                                res_status_next = STAT_INVALID;
                            end else if (below) begin
                                pos_next = pend_idx_ext + 1'b1;
                            end
                        end
                        OP_FIND: begin
                            if (hit) begin
                                lh_next         = pend_idx_reg;
                                lh_valid_next   = 1'b1;
                                res_idx_next    = pend_idx_reg;
                                res_region_next = ram_rdata;
                            end
                        end
                        OP_CHECK: begin
                            if (hit) begin
                                lh_next       = pend_idx_reg;
                                lh_valid_next = 1'b1;
                                cur_next      = ram_rdata.limit;
                                if (denied) begin
                                    res_status_next = STAT_DENIED;
                                end
                            end
                        end
                        default: res_status_next = STAT_OK;
                    endcase
                end else if (sweep_end) begin
                    if (op_reg == OP_MAP) begin
                        if (count_reg >= CNT_W'(MAX_REGIONS)) begin
                            res_status_next = STAT_FULL;
                        end else begin
                            // open a slot from the top down
                            issue_next = count_reg;
                        end
                    end else begin
                        res_status_next = STAT_NOT_FOUND;
                    end
                end
            end
            S_SHIFT: begin
                pend_valid_next = shift_issue;
                pend_idx_next   = issue_m1[IDX_W-1:0];
                if (shift_issue) begin
                    issue_next = issue_m1;
                end
            end
            S_INSERT: begin
                count_next = count_reg + 1'b1;
                // last hit follows its region up the table
                if (lh_valid_reg && (CNT_W'(lh_reg) >= pos_reg)) begin
                    lh_next = lh_reg + 1'b1;
                end
                res_idx_next          = pos_reg[IDX_W-1:0];
                res_region_next.base  = start_reg;
                res_region_next.limit = end_reg[ADDR_BITS-1:0];
                res_region_next.flags = flags_reg;
            end
            S_RESULT: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    out_status_next = res_status_reg;
                    out_idx_next    = res_idx_reg;
                    out_region_next = res_region_reg;
                end
            end
            default: begin
                pend_valid_next = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            lh_reg         <= '0;
            lh_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            win_low_reg    <= WIN_LOW_RST;
            win_high_reg   <= WIN_HIGH_RST;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            lh_reg         <= lh_next;
            lh_valid_reg   <= lh_valid_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            win_low_reg    <= win_low_next;
            win_high_reg   <= win_high_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        start_reg      <= start_next;
        cur_reg        <= cur_next;
        len_reg        <= len_next;
        flags_reg      <= flags_next;
        wr_reg         <= wr_next;
        end_reg        <= end_next;
        issue_reg      <= issue_next;
        pos_reg        <= pos_next;
        pend_idx_reg   <= pend_idx_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        res_region_reg <= res_region_next;
        out_status_reg <= out_status_next;
        out_idx_reg    <= out_idx_next;
        out_region_reg <= out_region_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = out_status_reg;
    assign m_region_index = out_idx_reg;
    assign m_found_start  = out_region_reg.base;
    assign m_found_end    = out_region_reg.limit;
    assign m_found_flags  = out_region_reg.flags;

    // table never holds more than its depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_REGIONS))
        else $error("region count beyond table depth");

    // a remembered last hit always points inside the table
    a_last_hit_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        lh_valid_reg |-> (CNT_W'(lh_reg) < count_reg))
        else $error("last hit outside table");

    // the table is only written while opening a slot or inserting
    a_ram_write_state: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> ((state_reg == S_SHIFT) || (state_reg == S_INSERT)))
        else $error("table write outside insert");

    // an insert grows the table by exactly one
    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_INSERT) |=> (count_reg == CNT_W'($past(count_reg) + 1'b1)))
        else $error("insert did not grow table");

    // an accepted word always starts the sequencer
    a_leave_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg != S_IDLE))
        else $error("accepted word left sequencer idle");

endmodule
